// ===== sv/rrv_pkg.sv =====
// Package: shared types and constants for the rolling return volatility block.
package rrv_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANNUAL_SCALE = 1'd1;
    localparam logic [6:0] WINDOW_RESET = 7'd20;
    localparam logic [23:0] SCALE_RESET = 24'd80255;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_DIV,
        t_ST_RET,
        t_ST_READ,
        t_ST_ACC,
        t_ST_NUM,
        t_ST_VDIV,
        t_ST_SQRT,
        t_ST_ANN,
        t_ST_OUT
    } t_state;

endpackage

// ===== sv/rrv_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rrv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/rrv_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module rrv_divider #(
    parameter int unsigned NW = 128,
    parameter int unsigned DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;

    // shift next numerator bit into remainder and try subtract
    always_comb begin
        n_trial = {r_rem[DW-1:0], r_quo[NW-1]};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_diff[DW]) begin
                    r_rem <= n_diff;
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== sv/rolling_return_volatility_top.sv =====
// Top level: return former, ring memory walk, variance, root and gain.
// The time per bar depends on whether a return is formed and whether the window is full,
// plus output stalls; it is set by two 128-step serial divides, a walk over the window
// and a digit-by-digit root.
// Throughput: one bar at a time; the next is taken in the cycle after the result beat.
// Reset: synchronous active low; clears history counters and restores
// window_length 20 and annual_scale 80255. Ring contents stay undefined.
module rolling_return_volatility_top #(
    parameter int unsigned HISTORY_DEPTH = 64,
    parameter int unsigned FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,   // [31:0] close_price
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] bar_ret, [32] return_valid, [33] window_ready,
    // [65:34] window_vol, [105:66] annualized_vol, [111:106] zero
    output logic [111:0]                  m_axis_tdata
);
    import rrv_pkg::*;

    localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned HW = $clog2(HISTORY_DEPTH + 1);

    t_state r_state, n_state;
    logic [6:0]  r_win;
    logic [23:0] r_scale;
    logic [31:0] r_last;
    logic        r_last_ok;
    logic [AW-1:0] r_head;
    logic [HW-1:0] r_held;
    logic [31:0] r_close;
    logic        r_neg;
    logic [31:0] r_ret;
    logic        r_formed;
    logic        r_ready;
    logic [6:0]  r_n;
    logic [6:0]  r_i;
    logic        r_rvalid;
    logic signed [38:0] r_sum;
    logic [69:0] r_sq;
    logic [127:0] r_num;
    logic [63:0]  r_var;
    logic [31:0]  r_root;
    logic [63:0]  r_rem;
    logic [5:0]   r_sq_cnt;
    logic [31:0]  r_vol;
    logic [39:0]  r_ann;
    logic [1:0]   r_phase;

    // ring memory
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;

    rrv_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_head),
        .i_wdata(r_ret),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // shared divider
    logic         w_dstart;
    logic [127:0] w_dnum;
    logic [63:0]  w_dden;
    logic         w_ddone;
    logic [127:0] w_dquo;

    rrv_divider #(.NW(128), .DW(64)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (w_dnum),
        .i_den  (w_dden),
        .o_done (w_ddone),
        .o_quo  (w_dquo)
    );

    logic [31:0]  w_mag;
    logic [127:0] w_rnum;
    logic [13:0]  w_nn1;
    logic [127:0] w_big;
    logic [127:0] w_smag2;
    logic [38:0]  w_smag;
    logic [AW:0]  w_ridx;
    logic [56:0]  w_prod;
    logic [31:0]  w_x;
    logic [31:0]  w_xm;
    logic [127:0] w_q;
    logic         w_ready;

    always_comb begin
        w_mag  = r_neg ? (r_last - r_close) : (r_close - r_last);
        w_rnum = 128'(({32'd0, w_mag} << FRAC_BITS) + {33'd0, r_last[31:1]});
        w_nn1  = 14'(r_n) * 14'(r_n - 7'd1);
        w_smag = r_sum[38] ? 39'(-r_sum) : 39'(r_sum);
        w_big  = 128'(r_sq) * 128'(r_n);
        w_smag2 = 128'(w_smag) * 128'(w_smag);
        w_q    = w_dquo;
        w_ready = (32'(r_held) >= 32'(r_n));
        // read newest-first walk address, wrap on underflow
        w_ridx = {1'b0, r_head} - (AW+1)'(r_i) - (AW+1)'(1);
        if (w_ridx[AW] || w_ridx >= (AW+1)'(HISTORY_DEPTH)) begin
            w_raddr = AW'(w_ridx + (AW+1)'(HISTORY_DEPTH));
        end else begin
            w_raddr = AW'(w_ridx);
        end
        w_x    = w_rdata;
        w_xm   = w_x[31] ? (32'd0 - w_x) : w_x;
        w_prod = 57'(r_vol) * 57'(r_scale);
        w_we   = (r_state == t_ST_RET) && r_formed;
        w_dstart = 1'b0;
        w_dnum = w_rnum;
        w_dden = {32'd0, r_last};
        if (r_state == t_ST_DIV && r_phase == 2'd0) w_dstart = 1'b1;
        if (r_state == t_ST_NUM) begin
            w_dstart = 1'b1;
            w_dnum = w_big - w_smag2;
            w_dden = 64'(w_nn1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE: if (s_axis_tvalid) n_state = t_ST_DIV;
            t_ST_DIV:  if (!r_formed || (r_phase == 2'd1 && w_ddone)) n_state = t_ST_RET;
            t_ST_RET:  n_state = t_ST_READ;
            t_ST_READ: n_state = w_ready ? t_ST_ACC : t_ST_OUT;
            t_ST_ACC:  if (r_i == r_n && r_rvalid == 1'b0) n_state = t_ST_NUM;
            t_ST_NUM:  n_state = t_ST_VDIV;
            t_ST_VDIV: if (w_ddone) n_state = t_ST_SQRT;
            t_ST_SQRT: if (r_sq_cnt == 6'd32) n_state = t_ST_ANN;
            t_ST_ANN:  n_state = t_ST_OUT;
            t_ST_OUT:  if (m_axis_tready) n_state = t_ST_IDLE;
            default:   n_state = t_ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= WINDOW_RESET;
            r_scale   <= SCALE_RESET;
            r_last_ok <= 1'b0;
            r_last    <= '0;
            r_head    <= '0;
            r_held    <= '0;
            r_phase   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_LENGTH: r_win <= i_cfg_data[6:0];
                    REG_ANNUAL_SCALE:  r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                t_ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_close  <= s_axis_tdata;
                        r_neg    <= s_axis_tdata < r_last;
                        r_formed <= r_last_ok && (r_last != 32'd0);
                        r_ret    <= '0;
                        r_phase  <= 2'd0;
                        r_n      <= (r_win < 7'd2) ? 7'd2 : r_win;
                    end
                end
                t_ST_DIV: begin
                    if (r_phase == 2'd0) r_phase <= 2'd1;
                    if (r_phase == 2'd1 && w_ddone) begin
                        if (r_neg) r_ret <= (w_q >= 128'h8000_0000) ? 32'h8000_0000
                                                                   : 32'd0 - w_q[31:0];
                        else r_ret <= (w_q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_q[31:0];
                    end
                end
                t_ST_RET: begin
                    r_last    <= r_close;
                    r_last_ok <= 1'b1;
                    if (r_formed) begin
                        r_head <= (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        if (r_held < HW'(HISTORY_DEPTH)) r_held <= r_held + 1'b1;
                    end
                end
                t_ST_READ: begin
                    r_ready  <= w_ready;
                    r_i      <= 7'd0;
                    r_rvalid <= 1'b0;
                    r_sum    <= '0;
                    r_sq     <= '0;
                    r_vol    <= '0;
                    r_ann    <= '0;
                end
                t_ST_ACC: begin
                    // issue read r_i, accumulate the previous one
                    if (r_i != r_n) r_i <= r_i + 1'b1;
                    r_rvalid <= (r_i != r_n);
                    if (r_rvalid) begin
                        r_sum <= r_sum + 39'(signed'(w_x));
                        r_sq  <= r_sq + 70'(64'(w_xm) * 64'(w_xm));
                    end
                end
                t_ST_NUM: ;
                t_ST_VDIV: begin
                    r_sq_cnt <= 6'd0;
                    r_root   <= '0;
                    r_rem    <= '0;
                    if (w_ddone) begin
                        r_var <= (w_q[127:64] != 64'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : w_q[63:0];
                        r_num <= w_q;
                    end
                end
                t_ST_SQRT: begin
                    // digit-by-digit root, two radicand bits per cycle
                    if (r_sq_cnt != 6'd32) begin
                        logic [65:0] t_rem;
                        logic [65:0] t_try;
                        t_rem = {r_rem, r_var[63:62]};
                        t_try = {32'd0, r_root, 2'b01};
                        r_var <= {r_var[61:0], 2'b00};
                        if (t_rem >= t_try) begin
                            r_rem  <= 64'(t_rem - t_try);
                            r_root <= {r_root[30:0], 1'b1};
                        end else begin
                            r_rem  <= 64'(t_rem);
                            r_root <= {r_root[30:0], 1'b0};
                        end
                        r_sq_cnt <= r_sq_cnt + 1'b1;
                    end else begin
                        // take the root, saturate when the variance overflowed
                        r_vol <= (r_num[127:64] != 64'd0) ? 32'hFFFF_FFFF : r_root;
                    end
                end
                t_ST_ANN: begin
                    // apply the gain, drop 8 fraction bits, saturate to 40 bits
                    r_ann <= (w_prod[56:48] != 9'd0) ? 40'hFF_FFFF_FFFF : w_prod[47:8];
                end
                t_ST_OUT: ;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == t_ST_IDLE);
    assign m_axis_tvalid = (r_state == t_ST_OUT);
    assign m_axis_tdata  = {6'd0, r_ann, r_vol, r_ready, r_formed, r_ret};

    // checks
    a_held_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= HISTORY_DEPTH) else $error("held count overflow");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
